// ----- rtl/rld_pkg.sv -----
`timescale 1ns / 1ps
// rld_pkg: shared types and constants for the run-length decoder.
// No dependencies; imported by rld_emitter, rle_literal_repeat_decoder and tb.
package rld_pkg;

  // Decoded element as it appears on the result channel.
  typedef logic [7:0] elem_t;

  // Width of a run count. Headers are one byte with the repeat flag on top.
  localparam int CNT_W          = 7;
  localparam int HDR_REPEAT_BIT = 7;

  // pair_count codes
  localparam logic [1:0] PAIR_ONE = 2'd1;
  localparam logic [1:0] PAIR_TWO = 2'd2;

  // Emit request from the parser to the result emitter.
  typedef struct packed {
    elem_t            elem;
    logic [CNT_W-1:0] count;  // copies of elem to emit, never zero
  } cmd_t;

endpackage

// ----- rtl/rld_emitter.sv -----
`timescale 1ns / 1ps
// rld_emitter: output register plus run counter that expands one emit
// request into results of up to two elements each. Depends on rld_pkg.
module rld_emitter
  import rld_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_ready,
  output logic       out_valid,
  input  logic       out_stall,
  output elem_t      out_first_elem,
  output elem_t      out_second_elem,
  output logic [1:0] out_pair_count,
  output logic       out_run_last
);

  logic             out_valid_r;
  logic [CNT_W-1:0] left_r;
  logic [CNT_W-1:0] left_nxt;
  elem_t            first_r;
  elem_t            second_r;
  logic [1:0]       pair_r;
  logic             last_r;

  logic             out_take;
  logic             load_cmd;
  logic             load_next;
  logic [CNT_W-1:0] operand;
  logic             two;
  elem_t            elem_sel;

  assign out_take  = out_valid_r && !out_stall;
  assign cmd_ready = !out_valid_r || (out_take && (left_r == '0));
  assign load_cmd  = cmd_valid && cmd_ready;
  assign load_next = out_take && (left_r != '0);

  // single shared compare / subtract-by-two unit
  assign operand  = load_cmd ? cmd.count : left_r;
  assign two      = operand >= CNT_W'(2);
  assign left_nxt = two ? (operand - CNT_W'(2)) : '0;
  assign elem_sel = load_cmd ? cmd.elem : first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      left_r      <= '0;
    end else begin
      if (load_cmd || load_next) begin
        out_valid_r <= 1'b1;
        left_r      <= left_nxt;
        first_r     <= elem_sel;
        second_r    <= two ? elem_sel : '0;
        pair_r      <= two ? PAIR_TWO : PAIR_ONE;
        last_r      <= (left_nxt == '0);
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_first_elem  = first_r;
  assign out_second_elem = second_r;
  assign out_pair_count  = pair_r;
  assign out_run_last    = last_r;

`ifndef NO_ASSERTIONS
  // pending copies only exist behind a held result
  a_left_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (left_r != '0) |-> out_valid_r)
    else $error("run count pending with empty output register");

  // a result that is not the last must have more copies queued
  a_not_last_has_more: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !last_r) |-> (left_r != '0))
    else $error("non-final result with no remaining copies");

  // a single-element result closes its run and carries a zero second element
  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (pair_r == PAIR_ONE)) |-> (last_r && (second_r == '0)))
    else $error("single-element result malformed");

  // parser never issues a request the emitter cannot take
  a_cmd_taken: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid |-> cmd_ready)
    else $error("emit request dropped");
`endif

endmodule

// ----- rtl/rle_literal_repeat_decoder.sv -----
`timescale 1ns / 1ps
// rle_literal_repeat_decoder: top level, header/element parser feeding the
// result emitter. Depends on rld_pkg and rld_emitter.

// Run-length decoder for a byte stream of literal and repeated runs. A header
// byte holds the run length in its low LEN_BITS bits and the repeat flag in
// bit 7. Elements are ELEM_BYTES stream bytes; only the first (low) byte of
// each element is kept. Literal runs emit one single-element result per
// element. A repeated run reads one element and emits it length times, two per
// result; run_last marks the final result caused by a byte. in_block_end
// forces the next byte to be parsed as a header and drops any partial run.
// Every input transaction, header bytes included, waits until the output
// register is empty or its last pending result leaves in that cycle. A
// literal element byte loads one result. A final repeated-element byte loads
// a run of ceil(length/2) results, paced one per cycle by the emitter's
// shared run counter (compare and subtract-by-two) while out_stall is low,
// and the input stalls until the last of them leaves. A zero-length repeat
// loads nothing. A new transaction is accepted in the cycle the last result
// of the previous one leaves the output register.
module rle_literal_repeat_decoder
  import rld_pkg::*;
#(
  parameter int ELEM_BYTES = 1,  // 1..4
  parameter int LEN_BITS   = 7   // 2..7
) (
  input  logic       clk,
  input  logic       rst_n,
  // compressed stream input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_stream_byte,
  input  logic       in_block_end,
  // decoded result output
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_first_elem,
  output logic [7:0] out_second_elem,
  output logic [1:0] out_pair_count,
  output logic       out_run_last
);

  localparam int IDX_W = (ELEM_BYTES > 1) ? $clog2(ELEM_BYTES) : 1;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [LEN_BITS-1:0] remaining_r, remaining_nxt;  // literal elements left / repeat count
  logic [IDX_W-1:0]    idx_r, idx_nxt;              // byte position inside element
  elem_t               elem_r, elem_nxt;            // first byte of current element

  logic                in_accept;
  logic                elem_done;
  logic                cmd_valid;
  logic                cmd_ready;
  cmd_t                cmd;
  logic [LEN_BITS-1:0] hdr_len;

  assign in_stall  = !cmd_ready;
  assign in_accept = in_valid && !in_stall;
  assign elem_done = (idx_r == IDX_W'(ELEM_BYTES - 1));
  assign hdr_len   = in_stream_byte[LEN_BITS-1:0];

  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    idx_nxt       = idx_r;
    elem_nxt      = elem_r;
    cmd_valid     = 1'b0;
    cmd.elem      = elem_r;
    cmd.count     = CNT_W'(1);
    if (in_accept) begin
      unique case (phase_r) inside
        PH_HEADER: begin
          remaining_nxt = hdr_len;
          idx_nxt       = '0;
          if (in_stream_byte[HDR_REPEAT_BIT]) begin
            phase_nxt = PH_REPEAT;
          end else if (hdr_len != '0) begin
            phase_nxt = PH_LITERAL;
          end
        end
        PH_LITERAL, PH_REPEAT: begin
          if (idx_r == '0) begin
            elem_nxt = in_stream_byte;
            cmd.elem = in_stream_byte;
          end
          if (elem_done) begin
            idx_nxt = '0;
            if (phase_r == PH_REPEAT) begin
              // zero-length repeat consumes the element and emits nothing
              cmd.count     = CNT_W'(remaining_r);
              cmd_valid     = (remaining_r != '0);
              remaining_nxt = '0;
              phase_nxt     = PH_HEADER;
            end else begin
              cmd_valid     = 1'b1;
              remaining_nxt = remaining_r - LEN_BITS'(1);
              if (remaining_r == LEN_BITS'(1)) begin
                phase_nxt = PH_HEADER;
              end
            end
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
      // block end abandons any partial run or element
      if (in_block_end) begin
        phase_nxt     = PH_HEADER;
        remaining_nxt = '0;
        idx_nxt       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      remaining_r <= '0;
      idx_r       <= '0;
    end else begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      idx_r       <= idx_nxt;
    end
    elem_r <= elem_nxt;
  end

  rld_emitter u_emitter (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_ready       (cmd_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_first_elem  (out_first_elem),
    .out_second_elem (out_second_elem),
    .out_pair_count  (out_pair_count),
    .out_run_last    (out_run_last)
  );

`ifndef NO_ASSERTIONS
  // a literal run in progress always has elements left
  a_literal_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LITERAL) |-> (remaining_r != '0))
    else $error("literal phase with zero remaining count");

  // an element byte index beyond the first only exists inside a run
  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != '0) |-> (phase_r != PH_HEADER))
    else $error("element byte index set while awaiting header");

  // block end always returns the parser to header parsing
  a_block_end_header: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_block_end) |=> ((phase_r == PH_HEADER) && (remaining_r == '0)))
    else $error("block end did not reset parser");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking testbench for rle_literal_repeat_decoder.
// Depends on rld_pkg and the decoder RTL; holds its own decode predictor.
module tb;
  import rld_pkg::*;

  // DUT configuration. The predictor and the stream generator both follow
  // these, so a different build only needs the two values changed here.
  localparam int ELEM_BYTES = 1;
  localparam int LEN_BITS   = 7;
  localparam logic [7:0] LEN_MASK = 8'((1 << LEN_BITS) - 1);

  // Cycles with no transaction on either channel before the run is declared
  // hung. The longest legal quiet stretch is the deliberate receiver hold plus
  // a sender gap, so this leaves a wide margin.
  localparam int HANG_LIMIT   = 3000;
  // Cycles to keep watching after the last expected result has arrived.
  localparam int SETTLE_CYCLES = 20;
  // Mismatch lines printed before further ones are only counted.
  localparam int MAX_PRINTED  = 40;

  typedef enum logic [1:0] {PH_HEADER, PH_LITERAL, PH_REPEAT} parse_phase_t;
  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

  // One decoded result transaction as seen on the out_ channel.
  typedef struct packed {
    logic [7:0] elem_a;
    logic [7:0] elem_b;
    logic [1:0] pairs;
    logic       run_last;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_stream_byte = 8'h00;
  logic       in_block_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_first_elem;
  logic [7:0] out_second_elem;
  logic [1:0] out_pair_count;
  logic       out_run_last;

  rle_literal_repeat_decoder #(
    .ELEM_BYTES(ELEM_BYTES),
    .LEN_BITS  (LEN_BITS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_stream_byte (in_stream_byte),
    .in_block_end   (in_block_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_first_elem (out_first_elem),
    .out_second_elem(out_second_elem),
    .out_pair_count (out_pair_count),
    .out_run_last   (out_run_last)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the parser registers.
  // ---------------------------------------------------------------------------
  parse_phase_t     ph = PH_HEADER;
  logic [CNT_W-1:0] run_left = '0;
  logic             rep_run = 1'b0;
  logic [7:0]       held_elem = 8'h00;
  int               byte_idx = 0;

  decoded_t decoded_q[$];   // results predicted but not yet seen, oldest first
  int       errors = 0;
  int       sent_count = 0;

  // Idling controls shared by the test tasks, the sender and the receiver.
  bit       sender_gaps = 1'b0;
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_FREE;
  int       hold_left = 0;      // long receiver hold-off, counted down below
  int       rx_tick = 0;
  int       quiet_cycles = 0;

  task automatic flag_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  task automatic expect_result(input logic [7:0] a, input logic [7:0] b,
                               input logic [1:0] pairs, input logic last_one);
    decoded_t r;
    r.elem_a   = a;
    r.elem_b   = b;
    r.pairs    = pairs;
    r.run_last = last_one;
    decoded_q.push_back(r);
  endtask

  // Advance the predictor by one accepted stream byte and queue whatever
  // results that byte produces. run_last is known up front: a literal element
  // yields exactly one result, a repeat element ceil(count/2) of them.
  task automatic decode_byte(input logic [7:0] b, input logic blk_end);
    logic [7:0] len;
    int left;
    len = b & LEN_MASK;
    if (ph == PH_HEADER) begin
      rep_run  = b[HDR_REPEAT_BIT];
      run_left = CNT_W'(len);
      byte_idx = 0;
      if (rep_run) begin
        ph = PH_REPEAT;
      end else if (len != 0) begin
        ph = PH_LITERAL;
      end
    end else begin
      // only the low byte of a multi-byte element survives
      if (byte_idx == 0) held_elem = b;
      byte_idx++;
      if (byte_idx >= ELEM_BYTES) begin
        byte_idx = 0;
        if (rep_run) begin
          left = run_left;
          // zero count: element consumed, nothing emitted
          while (left >= 2) begin
            expect_result(held_elem, held_elem, PAIR_TWO, left == 2);
            left -= 2;
          end
          if (left == 1) expect_result(held_elem, 8'h00, PAIR_ONE, 1'b1);
          run_left = '0;
          ph = PH_HEADER;
        end else begin
          expect_result(held_elem, 8'h00, PAIR_ONE, 1'b1);
          run_left = run_left - 1'b1;
          if (run_left == 0) ph = PH_HEADER;
        end
      end
    end
    // block end drops any partial run or element
    if (blk_end) begin
      ph = PH_HEADER;
      run_left = '0;
      byte_idx = 0;
    end
  endtask

  // Offer one byte and hold it until the DUT takes it. Valid stays high into
  // the next call unless the current burst has run out, which keeps
  // back-to-back transactions possible.
  task automatic send_byte(input logic [7:0] b, input logic blk_end);
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    in_block_end   <= blk_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b, blk_end);
    sent_count++;
    if (sender_gaps) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stop offering and wait for every predicted result to come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  // Idling profile per segment: none, gaps + random stalls,
  // gaps + fixed stall pattern, back-to-back input + random stalls.
  task automatic set_idling(input int seg);
    case (seg % 4)
      0: begin
        sender_gaps = 1'b0;
        rx_mode = RX_FREE;
      end
      1: begin
        sender_gaps = 1'b1;
        rx_mode = RX_RANDOM;
      end
      2: begin
        sender_gaps = 1'b1;
        rx_mode = RX_PATTERN;
      end
      default: begin
        sender_gaps = 1'b0;
        rx_mode = RX_RANDOM;
      end
    endcase
  endtask

  // One header plus its element bytes. cut_at >= 0 puts block_end on that
  // byte (0 = header) and abandons the rest of the run.
  task automatic send_run(input bit rep, input int len, input int cut_at,
                          input bit end_on_last);
    int nbytes;
    bit e;
    nbytes = (rep ? 1 : len) * ELEM_BYTES;
    send_byte({rep, 7'(len)}, cut_at == 0 || (nbytes == 0 && end_on_last));
    if (cut_at == 0) return;
    for (int i = 0; i < nbytes; i++) begin
      e = (i + 1 == cut_at) || (i == nbytes - 1 && end_on_last);
      send_byte(8'($urandom_range(0, 255)), e);
      if (i + 1 == cut_at) break;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern of its own, overridden by a long hold when asked.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rx_tick++;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      case (rx_mode)
        RX_RANDOM:  out_stall <= ($urandom_range(0, 99) < 35);
        RX_PATTERN: out_stall <= ((rx_tick % 7) < 3) || ((rx_tick % 29) == 11);
        default:    out_stall <= 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        flag_mismatch("result with nothing expected", out_first_elem, 0);
      end else begin
        want = decoded_q.pop_front();
        if (out_first_elem !== want.elem_a)
          flag_mismatch("first_elem", out_first_elem, want.elem_a);
        if (out_second_elem !== want.elem_b)
          flag_mismatch("second_elem", out_second_elem, want.elem_b);
        if (out_pair_count !== want.pairs)
          flag_mismatch("pair_count", out_pair_count, want.pairs);
        if (out_run_last !== want.run_last)
          flag_mismatch("run_last", out_run_last, want.run_last);
      end
    end
  end

  // Watchdog: any transaction on either side counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT) begin
          $display("%0t no progress, %0d results outstanding", $realtime,
                   decoded_q.size());
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked stream: field extremes and each corner of the header format.
  task automatic test_directed();
    set_idling(1);
    send_byte(8'h00, 1'b0);                 // empty literal run
    send_byte(8'h01, 1'b0);                 // literal, one element
    send_byte(8'h00, 1'b0);
    send_byte(8'h03, 1'b0);                 // literal, three elements
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h80, 1'b0);                 // empty repeat: element eaten
    send_byte(8'h5A, 1'b0);
    send_byte(8'h81, 1'b0);                 // repeat of one: single half result
    send_byte(8'h33, 1'b0);
    send_byte(8'h82, 1'b0);                 // repeat of two: one full pair
    send_byte(8'hC3, 1'b0);
    send_byte(8'hFF, 1'b0);                 // longest repeat, odd count
    send_byte(8'hFF, 1'b0);
    send_byte(8'h05, 1'b0);                 // block end cuts a literal run
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
    send_byte(8'h84, 1'b1);                 // block end on the header itself
    send_byte(8'h83, 1'b0);                 // block end on the repeat element
    send_byte(8'h7E, 1'b1);
    send_byte(8'h02, 1'b0);                 // normal literal after block ends
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    wait_drained();
  endtask

  // Mostly well-formed runs with random content, some truncated runs and
  // some raw noise. The idling profile changes between runs, every 70 bytes.
  task automatic test_random_streams(input int n_bytes);
    int target, seg, roll, len, nbytes, cut_at;
    bit rep;
    target = sent_count + n_bytes;
    seg = 0;
    set_idling(seg);
    while (sent_count < target) begin
      if (sent_count >= target - n_bytes + 70 * (seg + 1)) begin
        seg++;
        set_idling(seg);
      end
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        rep = $urandom_range(0, 1);
        roll = $urandom_range(0, 99);
        if (roll < 10) len = 0;
        else if (roll < 75) len = $urandom_range(1, 8);
        else if (roll < 93) len = $urandom_range(9, 40);
        else len = $urandom_range(41, 127);
        if (!rep && len > 40) len = $urandom_range(41, 127) / 3;
        nbytes = (rep ? 1 : len) * ELEM_BYTES;
        cut_at = ($urandom_range(0, 99) < 8) ? $urandom_range(0, nbytes) : -1;
        send_run(rep, len, cut_at, $urandom_range(0, 99) < 15);
      end
    end
    wait_drained();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // long repeat runs, so the decoder backs up and stalls its input.
  task automatic test_output_backpressure();
    sender_gaps = 1'b0;
    rx_mode = RX_FREE;
    hold_left = 250;
    for (int i = 0; i < 10; i++) begin
      send_run(1'b1, $urandom_range(60, 127), -1, 1'b0);
      send_run(1'b0, $urandom_range(1, 3), -1, 1'b0);
    end
    wait_drained();
  endtask

  // Sender pauses until every result is out, then resumes; covers the
  // decoder going fully idle in the middle of a stream.
  task automatic test_drain_then_resume();
    set_idling(2);
    for (int i = 0; i < 6; i++) begin
      send_run(1'b1, $urandom_range(0, 127), -1, 1'b0);
      send_run(1'b0, $urandom_range(0, 4), -1, i[0]);
      wait_drained();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_streams(340);
    test_output_backpressure();
    test_drain_then_resume();

    // everything has been predicted and seen; watch a little longer for
    // stray results before the verdict
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rld_pkg.sv
rtl/rld_emitter.sv
rtl/rle_literal_repeat_decoder.sv
tb/tb.sv
